[rtl/cpt_pkg.sv]
package cpt_pkg;

    // Defaults for the top-level parameters
    localparam int DATA_WIDTH_DEF      = 16;
    localparam int ANGLE_WIDTH_DEF     = 16;
    localparam int TRIG_TABLE_BITS_DEF = 10;

    // Sine/cosine: signed Q1.15, table magnitude is 15 bits
    localparam int TRIG_W     = 16;
    localparam int TRIG_MAG_W = 15;
    localparam logic [TRIG_MAG_W-1:0] TRIG_MAG_MAX = {TRIG_MAG_W{1'b1}};

    // Q16 transform constants
    localparam logic [15:0] K_THIRD      = 16'd21845;
    localparam logic [15:0] K_INV_SQRT3  = 16'd37837;
    localparam logic [15:0] K_HALF_SQRT3 = 16'd56756;

    // Rounding shifts
    localparam int CLARKE_SHIFT = 16;
    localparam int ROT_SHIFT    = 15;

    // pi/2 in Q30, for table generation
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam int          TAYLOR_TERMS = 16;

    typedef enum logic {
        CMD_FORWARD = 1'b0,
        CMD_INVERSE = 1'b1
    } cmd_t;

    // Stage advance enables, one per pipeline register
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } pipe_en_t;

    // Unsigned quotient by shift and subtract; table generation only
    function automatic logic [63:0] udiv64(input logic [63:0] num,
                                           input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Quarter-wave entry k of a 2^bits table: sin(pi/2 * k / 2^bits), Q1.15.
    // Evaluated at elaboration only.
    function automatic logic [TRIG_MAG_W-1:0] sine_entry(input int unsigned k,
                                                         input int unsigned bits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x    = (HALF_PI_Q30 * 64'(k)) >> bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (int n = 1; n < TAYLOR_TERMS; n++) begin
            term = (term * x2) >> 30;
            term = udiv64(term, 64'(2 * n) * 64'(2 * n + 1));
            if (n[0]) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        sum = (sum + 64'sd16384) >>> 15;
        if (sum > $signed({49'd0, TRIG_MAG_MAX})) begin
            sum = $signed({49'd0, TRIG_MAG_MAX});
        end
        return sum[TRIG_MAG_W-1:0];
    endfunction

endpackage

[rtl/clarke_park_transform_unit_top.sv]
// Clarke/Park transform unit, forward (abc -> alpha/beta -> dq) or inverse per transaction.
// A result passes through five register stages (s1 to s5) between the acceptance of its input
// transaction and the output.
// Throughput: one transaction per cycle; every stage holds its own valid bit, so a
// stall at the output backs up only through full stages and bubbles are squeezed out.
// Reset: aresetn synchronous, active low; clears the stage valid bits only, the block
// keeps no other state and the sine table is constant, so no clearing pass is needed.
module clarke_park_transform_unit_top #(
    parameter int DATA_WIDTH      = cpt_pkg::DATA_WIDTH_DEF,
    parameter int ANGLE_WIDTH     = cpt_pkg::ANGLE_WIDTH_DEF,
    parameter int TRIG_TABLE_BITS = cpt_pkg::TRIG_TABLE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    // input channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [0:0]                   s_command,
    input  logic signed [DATA_WIDTH-1:0] s_phase_a,
    input  logic signed [DATA_WIDTH-1:0] s_phase_b,
    input  logic signed [DATA_WIDTH-1:0] s_phase_c,
    input  logic signed [DATA_WIDTH-1:0] s_value_d,
    input  logic signed [DATA_WIDTH-1:0] s_value_q,
    input  logic [ANGLE_WIDTH-1:0]       s_angle,

    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0] m_alpha_out,
    output logic signed [DATA_WIDTH-1:0] m_beta_out,
    output logic signed [DATA_WIDTH-1:0] m_d_out,
    output logic signed [DATA_WIDTH-1:0] m_q_out,
    output logic signed [DATA_WIDTH-1:0] m_a_out,
    output logic signed [DATA_WIDTH-1:0] m_b_out,
    output logic signed [DATA_WIDTH-1:0] m_c_out
);

    // Stage map:
    //   s1  table lookup (both quarter-wave addresses) | Clarke sums 2a-b-c, b-c
    //   s2  quadrant sign/select -> sin, cos           | Clarke scaling, round, saturate
    //   s3  operand select (alpha/beta or d/q), four rotation products
    //   s4  rotation sums, round, saturate -> (d,q) or (alpha,beta)
    //   s5  inverse Clarke for b, c and output select; this is the output register

    // Valid bits travel with the data, one per stage
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic v4_reg;
    logic v5_reg;

    // A stage may load when it is empty or the stage after it loads this cycle
    cpt_pkg::pipe_en_t en;

    assign en.s5 = !v5_reg || m_ready;
    assign en.s4 = !v4_reg || en.s5;
    assign en.s3 = !v3_reg || en.s4;
    assign en.s2 = !v2_reg || en.s3;
    assign en.s1 = !v1_reg || en.s2;

    assign s_ready = en.s1;
    assign m_valid = v5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en.s1) begin
                v1_reg <= s_valid;
            end
            if (en.s2) begin
                v2_reg <= v1_reg;
            end
            if (en.s3) begin
                v3_reg <= v2_reg;
            end
            if (en.s4) begin
                v4_reg <= v3_reg;
            end
            if (en.s5) begin
                v5_reg <= v4_reg;
            end
        end
    end

    // Mode and inverse-mode operands ride alongside the trig and Clarke stages
    cpt_pkg::cmd_t                cmd1_reg;
    cpt_pkg::cmd_t                cmd2_reg;
    logic signed [DATA_WIDTH-1:0] vd1_reg;
    logic signed [DATA_WIDTH-1:0] vq1_reg;
    logic signed [DATA_WIDTH-1:0] vd2_reg;
    logic signed [DATA_WIDTH-1:0] vq2_reg;

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            cmd1_reg <= cpt_pkg::cmd_t'(s_command);
            vd1_reg  <= s_value_d;
            vq1_reg  <= s_value_q;
        end
        if (en.s2) begin
            cmd2_reg <= cmd1_reg;
            vd2_reg  <= vd1_reg;
            vq2_reg  <= vq1_reg;
        end
    end

    // sine and cosine, valid at stage 2
    logic signed [cpt_pkg::TRIG_W-1:0] sin_s2;
    logic signed [cpt_pkg::TRIG_W-1:0] cos_s2;

    cpt_trig #(
        .ANGLE_WIDTH    (ANGLE_WIDTH),
        .TRIG_TABLE_BITS(TRIG_TABLE_BITS)
    ) u_trig (
        .aclk   (aclk),
        .en     (en),
        .angle  (s_angle),
        .sin_out(sin_s2),
        .cos_out(cos_s2)
    );

    // forward Clarke, saturated alpha/beta at stage 2
    logic signed [DATA_WIDTH-1:0] alpha_s2;
    logic signed [DATA_WIDTH-1:0] beta_s2;

    cpt_clarke #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_clarke (
        .aclk   (aclk),
        .en     (en),
        .phase_a(s_phase_a),
        .phase_b(s_phase_b),
        .phase_c(s_phase_c),
        .alpha  (alpha_s2),
        .beta   (beta_s2)
    );

    // Park rotation in either direction, stages 3 and 4
    cpt_pkg::cmd_t                cmd_s4;
    logic signed [DATA_WIDTH-1:0] x_s4;
    logic signed [DATA_WIDTH-1:0] y_s4;
    logic signed [DATA_WIDTH-1:0] r0_s4;
    logic signed [DATA_WIDTH-1:0] r1_s4;

    cpt_rotate #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_rotate (
        .aclk   (aclk),
        .en     (en),
        .cmd_in (cmd2_reg),
        .alpha  (alpha_s2),
        .beta   (beta_s2),
        .value_d(vd2_reg),
        .value_q(vq2_reg),
        .sin_in (sin_s2),
        .cos_in (cos_s2),
        .cmd_out(cmd_s4),
        .x_out  (x_s4),
        .y_out  (y_s4),
        .r0_out (r0_s4),
        .r1_out (r1_s4)
    );

    // inverse Clarke and result register, stage 5
    cpt_inv_clarke #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_inv_clarke (
        .aclk     (aclk),
        .en       (en),
        .cmd      (cmd_s4),
        .x_in     (x_s4),
        .y_in     (y_s4),
        .r0_in    (r0_s4),
        .r1_in    (r1_s4),
        .alpha_out(m_alpha_out),
        .beta_out (m_beta_out),
        .d_out    (m_d_out),
        .q_out    (m_q_out),
        .a_out    (m_a_out),
        .b_out    (m_b_out),
        .c_out    (m_c_out)
    );

endmodule

[rtl/cpt_trig.sv]
module cpt_trig #(
    parameter int ANGLE_WIDTH     = cpt_pkg::ANGLE_WIDTH_DEF,
    parameter int TRIG_TABLE_BITS = cpt_pkg::TRIG_TABLE_BITS_DEF
) (
    input  logic                                aclk,
    input  cpt_pkg::pipe_en_t                   en,
    input  logic        [ANGLE_WIDTH-1:0]       angle,
    output logic signed [cpt_pkg::TRIG_W-1:0]   sin_out,
    output logic signed [cpt_pkg::TRIG_W-1:0]   cos_out
);

    localparam int PW    = ANGLE_WIDTH - 2;
    localparam int TB    = TRIG_TABLE_BITS;
    localparam int TOP   = 1 << TB;
    localparam int DEPTH = TOP + 1;
    localparam int IW    = TB + 1;

    typedef logic [cpt_pkg::TRIG_MAG_W-1:0] rom_t [DEPTH];

    function automatic rom_t build_rom();
        rom_t r;
        for (int k = 0; k < DEPTH; k++) begin
            r[k] = cpt_pkg::sine_entry(k, TB);
        end
        return r;
    endfunction

    localparam rom_t ROM = build_rom();

    logic [1:0]       quad;
    logic [PW+TB-1:0] scaled;
    logic [IW-1:0]    lo_idx;
    logic [IW-1:0]    hi_idx;

    // phase scaled to TB bits by truncation
    assign quad   = angle[ANGLE_WIDTH-1:ANGLE_WIDTH-2];
    assign scaled = {angle[PW-1:0], {TB{1'b0}}};
    assign lo_idx = {1'b0, scaled[PW+TB-1:PW]};
    assign hi_idx = IW'(TOP) - lo_idx;

    logic [cpt_pkg::TRIG_MAG_W-1:0] lo_reg;
    logic [cpt_pkg::TRIG_MAG_W-1:0] hi_reg;
    logic [1:0]                     quad_reg;

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            lo_reg   <= ROM[lo_idx];
            hi_reg   <= ROM[hi_idx];
            quad_reg <= quad;
        end
    end

    logic signed [cpt_pkg::TRIG_W-1:0] lo_s;
    logic signed [cpt_pkg::TRIG_W-1:0] hi_s;
    logic signed [cpt_pkg::TRIG_W-1:0] sin_next;
    logic signed [cpt_pkg::TRIG_W-1:0] cos_next;

    assign lo_s = $signed({1'b0, lo_reg});
    assign hi_s = $signed({1'b0, hi_reg});

    always_comb begin
        case (quad_reg)
            2'd0: begin
                sin_next = lo_s;
                cos_next = hi_s;
            end
            2'd1: begin
                sin_next = hi_s;
                cos_next = -lo_s;
            end
            2'd2: begin
                sin_next = -lo_s;
                cos_next = -hi_s;
            end
            default: begin
                sin_next = -hi_s;
                cos_next = lo_s;
            end
        endcase
    end

    logic signed [cpt_pkg::TRIG_W-1:0] sin_reg;
    logic signed [cpt_pkg::TRIG_W-1:0] cos_reg;

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_out = sin_reg;
    assign cos_out = cos_reg;

endmodule

[rtl/cpt_clarke.sv]
module cpt_clarke #(
    parameter int DATA_WIDTH = cpt_pkg::DATA_WIDTH_DEF
) (
    input  logic                         aclk,
    input  cpt_pkg::pipe_en_t            en,
    input  logic signed [DATA_WIDTH-1:0] phase_a,
    input  logic signed [DATA_WIDTH-1:0] phase_b,
    input  logic signed [DATA_WIDTH-1:0] phase_c,
    output logic signed [DATA_WIDTH-1:0] alpha,
    output logic signed [DATA_WIDTH-1:0] beta
);

    localparam int W  = DATA_WIDTH;
    localparam int PW = W + 18;

    localparam logic signed [PW-1:0] SAT_HI = $signed({{(PW-W+1){1'b0}}, {(W-1){1'b1}}});
    localparam logic signed [PW-1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [PW-1:0] RND    = PW'(1) <<< (cpt_pkg::CLARKE_SHIFT - 1);

    function automatic logic signed [W-1:0] sat_w(input logic signed [PW-1:0] v);
        if (v > SAT_HI) begin
            return SAT_HI[W-1:0];
        end else if (v < SAT_LO) begin
            return SAT_LO[W-1:0];
        end
        return v[W-1:0];
    endfunction

    // stage 1: sums
    logic signed [W+1:0] a_x;
    logic signed [W+1:0] b_x;
    logic signed [W+1:0] c_x;
    logic signed [W+1:0] sa_next;
    logic signed [W:0]   sb_next;

    assign a_x     = (W+2)'(phase_a);
    assign b_x     = (W+2)'(phase_b);
    assign c_x     = (W+2)'(phase_c);
    assign sa_next = (a_x <<< 1) - b_x - c_x;
    assign sb_next = (W+1)'(phase_b) - (W+1)'(phase_c);

    logic signed [W+1:0] sa_reg;
    logic signed [W:0]   sb_reg;

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            sa_reg <= sa_next;
            sb_reg <= sb_next;
        end
    end

    // stage 2: scale, round, saturate
    logic signed [PW-1:0] k_third;
    logic signed [PW-1:0] k_inv_sqrt3;
    logic signed [PW-1:0] prod_a;
    logic signed [PW-1:0] prod_b;
    logic signed [PW-1:0] sh_a;
    logic signed [PW-1:0] sh_b;
    logic signed [W-1:0]  alpha_next;
    logic signed [W-1:0]  beta_next;

    assign k_third     = $signed({1'b0, cpt_pkg::K_THIRD});
    assign k_inv_sqrt3 = $signed({1'b0, cpt_pkg::K_INV_SQRT3});
    assign prod_a      = PW'(sa_reg) * k_third;
    assign prod_b      = PW'(sb_reg) * k_inv_sqrt3;
    assign sh_a        = (prod_a + RND) >>> cpt_pkg::CLARKE_SHIFT;
    assign sh_b        = (prod_b + RND) >>> cpt_pkg::CLARKE_SHIFT;
    assign alpha_next  = sat_w(sh_a);
    assign beta_next   = sat_w(sh_b);

    logic signed [W-1:0] alpha_reg;
    logic signed [W-1:0] beta_reg;

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            alpha_reg <= alpha_next;
            beta_reg  <= beta_next;
        end
    end

    assign alpha = alpha_reg;
    assign beta  = beta_reg;

endmodule

[rtl/cpt_rotate.sv]
module cpt_rotate #(
    parameter int DATA_WIDTH = cpt_pkg::DATA_WIDTH_DEF
) (
    input  logic                               aclk,
    input  cpt_pkg::pipe_en_t                  en,
    input  cpt_pkg::cmd_t                      cmd_in,
    input  logic signed [DATA_WIDTH-1:0]       alpha,
    input  logic signed [DATA_WIDTH-1:0]       beta,
    input  logic signed [DATA_WIDTH-1:0]       value_d,
    input  logic signed [DATA_WIDTH-1:0]       value_q,
    input  logic signed [cpt_pkg::TRIG_W-1:0]  sin_in,
    input  logic signed [cpt_pkg::TRIG_W-1:0]  cos_in,
    output cpt_pkg::cmd_t                      cmd_out,
    output logic signed [DATA_WIDTH-1:0]       x_out,
    output logic signed [DATA_WIDTH-1:0]       y_out,
    output logic signed [DATA_WIDTH-1:0]       r0_out,
    output logic signed [DATA_WIDTH-1:0]       r1_out
);

    localparam int W  = DATA_WIDTH;
    localparam int MW = W + cpt_pkg::TRIG_W;
    localparam int SW = W + 17;

    localparam logic signed [SW-1:0] SAT_HI = $signed({{(SW-W+1){1'b0}}, {(W-1){1'b1}}});
    localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [SW-1:0] RND    = SW'(1) <<< (cpt_pkg::ROT_SHIFT - 1);

    function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] v);
        if (v > SAT_HI) begin
            return SAT_HI[W-1:0];
        end else if (v < SAT_LO) begin
            return SAT_LO[W-1:0];
        end
        return v[W-1:0];
    endfunction

    // stage 3: operand select and the four products
    logic signed [W-1:0]  x_sel;
    logic signed [W-1:0]  y_sel;
    logic signed [MW-1:0] xc_next;
    logic signed [MW-1:0] ys_next;
    logic signed [MW-1:0] xs_next;
    logic signed [MW-1:0] yc_next;

    assign x_sel   = (cmd_in == cpt_pkg::CMD_FORWARD) ? alpha : value_d;
    assign y_sel   = (cmd_in == cpt_pkg::CMD_FORWARD) ? beta  : value_q;
    assign xc_next = MW'(x_sel) * MW'(cos_in);
    assign ys_next = MW'(y_sel) * MW'(sin_in);
    assign xs_next = MW'(x_sel) * MW'(sin_in);
    assign yc_next = MW'(y_sel) * MW'(cos_in);

    cpt_pkg::cmd_t        cmd3_reg;
    logic signed [W-1:0]  x3_reg;
    logic signed [W-1:0]  y3_reg;
    logic signed [MW-1:0] xc_reg;
    logic signed [MW-1:0] ys_reg;
    logic signed [MW-1:0] xs_reg;
    logic signed [MW-1:0] yc_reg;

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            cmd3_reg <= cmd_in;
            x3_reg   <= x_sel;
            y3_reg   <= y_sel;
            xc_reg   <= xc_next;
            ys_reg   <= ys_next;
            xs_reg   <= xs_next;
            yc_reg   <= yc_next;
        end
    end

    // stage 4: sum, round, saturate
    // forward:  d = x.cos + y.sin, q = y.cos - x.sin
    // inverse:  alpha = x.cos - y.sin, beta = x.sin + y.cos
    logic signed [SW-1:0] sum0;
    logic signed [SW-1:0] sum1;
    logic signed [SW-1:0] sh0;
    logic signed [SW-1:0] sh1;
    logic signed [W-1:0]  r0_next;
    logic signed [W-1:0]  r1_next;

    always_comb begin
        if (cmd3_reg == cpt_pkg::CMD_FORWARD) begin
            sum0 = SW'(xc_reg) + SW'(ys_reg);
            sum1 = SW'(yc_reg) - SW'(xs_reg);
        end else begin
            sum0 = SW'(xc_reg) - SW'(ys_reg);
            sum1 = SW'(xs_reg) + SW'(yc_reg);
        end
    end

    assign sh0     = (sum0 + RND) >>> cpt_pkg::ROT_SHIFT;
    assign sh1     = (sum1 + RND) >>> cpt_pkg::ROT_SHIFT;
    assign r0_next = sat_w(sh0);
    assign r1_next = sat_w(sh1);

    cpt_pkg::cmd_t       cmd4_reg;
    logic signed [W-1:0] x4_reg;
    logic signed [W-1:0] y4_reg;
    logic signed [W-1:0] r0_reg;
    logic signed [W-1:0] r1_reg;

    always_ff @(posedge aclk) begin
        if (en.s4) begin
            cmd4_reg <= cmd3_reg;
            x4_reg   <= x3_reg;
            y4_reg   <= y3_reg;
            r0_reg   <= r0_next;
            r1_reg   <= r1_next;
        end
    end

    assign cmd_out = cmd4_reg;
    assign x_out   = x4_reg;
    assign y_out   = y4_reg;
    assign r0_out  = r0_reg;
    assign r1_out  = r1_reg;

endmodule

[rtl/cpt_inv_clarke.sv]
module cpt_inv_clarke #(
    parameter int DATA_WIDTH = cpt_pkg::DATA_WIDTH_DEF
) (
    input  logic                         aclk,
    input  cpt_pkg::pipe_en_t            en,
    input  cpt_pkg::cmd_t                cmd,
    input  logic signed [DATA_WIDTH-1:0] x_in,
    input  logic signed [DATA_WIDTH-1:0] y_in,
    input  logic signed [DATA_WIDTH-1:0] r0_in,
    input  logic signed [DATA_WIDTH-1:0] r1_in,
    output logic signed [DATA_WIDTH-1:0] alpha_out,
    output logic signed [DATA_WIDTH-1:0] beta_out,
    output logic signed [DATA_WIDTH-1:0] d_out,
    output logic signed [DATA_WIDTH-1:0] q_out,
    output logic signed [DATA_WIDTH-1:0] a_out,
    output logic signed [DATA_WIDTH-1:0] b_out,
    output logic signed [DATA_WIDTH-1:0] c_out
);

    localparam int W  = DATA_WIDTH;
    localparam int SW = W + 18;

    localparam logic signed [SW-1:0] SAT_HI = $signed({{(SW-W+1){1'b0}}, {(W-1){1'b1}}});
    localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [SW-1:0] RND    = SW'(1) <<< (cpt_pkg::CLARKE_SHIFT - 1);

    function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] v);
        if (v > SAT_HI) begin
            return SAT_HI[W-1:0];
        end else if (v < SAT_LO) begin
            return SAT_LO[W-1:0];
        end
        return v[W-1:0];
    endfunction

    // -alpha/2 in Q16 is a shift; beta.sqrt3/2 takes the multiplier
    logic signed [SW-1:0] k_half_sqrt3;
    logic signed [SW-1:0] neg_half_al;
    logic signed [SW-1:0] be_prod;
    logic signed [SW-1:0] b_sh;
    logic signed [SW-1:0] c_sh;
    logic                 fwd;

    assign k_half_sqrt3 = $signed({1'b0, cpt_pkg::K_HALF_SQRT3});
    assign neg_half_al  = -(SW'(r0_in) <<< (cpt_pkg::CLARKE_SHIFT - 1));
    assign be_prod      = SW'(r1_in) * k_half_sqrt3;
    assign b_sh         = (neg_half_al + be_prod + RND) >>> cpt_pkg::CLARKE_SHIFT;
    assign c_sh         = (neg_half_al - be_prod + RND) >>> cpt_pkg::CLARKE_SHIFT;
    assign fwd          = (cmd == cpt_pkg::CMD_FORWARD);

    logic signed [W-1:0] alpha_reg;
    logic signed [W-1:0] beta_reg;
    logic signed [W-1:0] d_reg;
    logic signed [W-1:0] q_reg;
    logic signed [W-1:0] a_reg;
    logic signed [W-1:0] b_reg;
    logic signed [W-1:0] c_reg;

    always_ff @(posedge aclk) begin
        if (en.s5) begin
            alpha_reg <= fwd ? x_in  : r0_in;
            beta_reg  <= fwd ? y_in  : r1_in;
            d_reg     <= fwd ? r0_in : '0;
            q_reg     <= fwd ? r1_in : '0;
            a_reg     <= fwd ? '0    : r0_in;
            b_reg     <= fwd ? '0    : sat_w(b_sh);
            c_reg     <= fwd ? '0    : sat_w(c_sh);
        end
    end

    assign alpha_out = alpha_reg;
    assign beta_out  = beta_reg;
    assign d_out     = d_reg;
    assign q_out     = q_reg;
    assign a_out     = a_reg;
    assign b_out     = b_reg;
    assign c_out     = c_reg;

endmodule
